// File: rtl/core/rca_pkg.sv
// Shared types, widths and constants of the region color averager.
// No dependencies; every other file of the block imports this package.
package rca_pkg;

   // Geometry limits.
   localparam int MAX_DIM      = 8192;
   localparam int GRID_DIVISOR = 8;
   localparam int COORD_W      = $clog2(MAX_DIM);          // column and line
   localparam int DIM_W        = COORD_W + 1;              // config sizes, clamped bounds
   localparam int GRID_TAPS    = 2 * GRID_DIVISOR;         // grid points an axis can hold
   localparam int TAP_W        = $clog2(GRID_TAPS);
   localparam int OFF_W        = DIM_W + TAP_W;            // multiples of the grid step

   // Pixel and color widths.
   localparam int PIX_W        = 32;
   localparam int COLOR_W      = 8;
   localparam int CH_W         = 10;                       // widest channel (10-bit format)
   localparam int NUM_CH       = 3;
   localparam int CH_RED       = 0;
   localparam int CH_GREEN     = 1;
   localparam int CH_BLUE      = 2;

   // Accumulation and division widths.
   localparam int CNT_W        = 24;
   localparam int SUM_W        = CH_W + CNT_W;
   localparam int NUM_W        = SUM_W + COLOR_W;          // sum * 255
   localparam int QUO_W        = COLOR_W;                  // mean is always below 256
   localparam int DIV_CNT_W    = $clog2(QUO_W);

   // Configuration port.
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = DIM_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 3'd0,
      CSR_FRAME_HEIGHT = 3'd1,
      CSR_AREA_LEFT    = 3'd2,
      CSR_AREA_TOP     = 3'd3,
      CSR_AREA_WIDTH   = 3'd4,
      CSR_AREA_HEIGHT  = 3'd5,
      CSR_PIXEL_FORMAT = 3'd6
   } csr_index_type;

   typedef enum logic {
      FMT_BGRA8 = 1'b0,
      FMT_RGB10 = 1'b1
   } pixel_format_type;

   typedef enum logic [1:0] {
      ST_ACCUM,
      ST_PREP,
      ST_DIVIDE,
      ST_DELIVER
   } state_type;

   typedef struct packed {
      logic [PIX_W-1:0]   pixel_word;
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] line;
      logic               end_of_frame;
   } req_word_type;

   typedef struct packed {
      logic [COLOR_W-1:0] mean_red;
      logic [COLOR_W-1:0] mean_green;
      logic [COLOR_W-1:0] mean_blue;
      logic               color_valid;
   } rsp_word_type;

   // One clamped axis of the region.
   typedef struct packed {
      logic [DIM_W-1:0] lo;
      logic [DIM_W-1:0] hi;
      logic [DIM_W-1:0] step;
      logic             ok;
   } axis_type;

   typedef struct packed {
      axis_type         x;
      axis_type         y;
      pixel_format_type fmt;
   } geom_type;

   // Controller to datapath.
   typedef struct packed {
      logic prep;
      logic div_step;
      logic load_out;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic frame_done;
      logic eof_in_pipe;
      logic out_full;
   } status_type;

endpackage

// File: rtl/core/rca_ifs.sv
// Valid/ready channel interfaces for pixel requests and color responses.
// Depends on rca_pkg for the word types.
interface rca_req_if;
   import rca_pkg::*;
   logic         valid;
   logic         ready;
   req_word_type word;
   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

interface rca_rsp_if;
   import rca_pkg::*;
   logic         valid;
   logic         ready;
   rsp_word_type word;
   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

// File: rtl/core/rca_csr.sv
// Configuration registers and the clamped region geometry derived from them.
// Depends on rca_pkg.
module rca_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [rca_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rca_pkg::CSR_DATA_W-1:0] csr_wdata,
   output rca_pkg::geom_type              geom
);
   import rca_pkg::*;

   logic [DIM_W-1:0] frame_width_ff;
   logic [DIM_W-1:0] frame_height_ff;
   logic [DIM_W-1:0] area_left_ff;
   logic [DIM_W-1:0] area_top_ff;
   logic [DIM_W-1:0] area_width_ff;
   logic [DIM_W-1:0] area_height_ff;
   pixel_format_type pixel_format_ff;
   geom_type         geom_ff;
   geom_type         geom_in;

   function automatic logic signed [DIM_W+1:0] clamp_top(
      input logic signed [DIM_W+1:0] v,
      input logic signed [DIM_W+1:0] top
   );
      logic signed [DIM_W+1:0] r;
      r = v;
      if (v < 0) r = '0;
      else if (v > top) r = top;
      return r;
   endfunction

   function automatic axis_type axis_clamp(
      input logic [DIM_W-1:0] start,
      input logic [DIM_W-1:0] span,
      input logic [DIM_W-1:0] size
   );
      logic signed [DIM_W+1:0] top_s;
      logic signed [DIM_W+1:0] start_s;
      logic signed [DIM_W+1:0] end_s;
      logic signed [DIM_W+1:0] lo_s;
      logic signed [DIM_W+1:0] hi_s;
      logic [DIM_W-1:0]        width_v;
      logic [DIM_W-1:0]        step_v;
      axis_type                a;
      top_s   = (size == '0) ? '0 : signed'({2'b00, size}) - (DIM_W+2)'(1);
      start_s = signed'({{2{start[DIM_W-1]}}, start});
      end_s   = start_s + signed'({2'b00, span});
      lo_s    = clamp_top(start_s, top_s);
      hi_s    = clamp_top(end_s, top_s);
      a.lo    = lo_s[DIM_W-1:0];
      a.hi    = hi_s[DIM_W-1:0];
      a.ok    = hi_s > lo_s;
      width_v = a.hi - a.lo;
      step_v  = DIM_W'(width_v / GRID_DIVISOR);
      if (step_v == '0) step_v = DIM_W'(1);
      a.step  = step_v;
      return a;
   endfunction

   // Register writes; an index past the list is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= DIM_W'(1920);
         frame_height_ff <= DIM_W'(1080);
         area_left_ff    <= '0;
         area_top_ff     <= '0;
         area_width_ff   <= DIM_W'(64);
         area_height_ff  <= DIM_W'(64);
         pixel_format_ff <= FMT_BGRA8;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata;
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            CSR_AREA_LEFT:    area_left_ff    <= csr_wdata;
            CSR_AREA_TOP:     area_top_ff     <= csr_wdata;
            CSR_AREA_WIDTH:   area_width_ff   <= csr_wdata;
            CSR_AREA_HEIGHT:  area_height_ff  <= csr_wdata;
            CSR_PIXEL_FORMAT: pixel_format_ff <= pixel_format_type'(csr_wdata[0]);
            default: ;
         endcase
      end
   end

   always_comb begin
      geom_in.x   = axis_clamp(area_left_ff, area_width_ff, frame_width_ff);
      geom_in.y   = axis_clamp(area_top_ff, area_height_ff, frame_height_ff);
      geom_in.fmt = pixel_format_ff;
   end

   always_ff @(posedge clock) begin
      geom_ff <= geom_in;
   end

   assign geom = geom_ff;

endmodule

// File: rtl/core/rca_datapath.sv
// Pixel pipeline, grid test, accumulators, shared-step divider and result register.
// Depends on rca_pkg; driven by rca_ctrl through cmd_type.
module rca_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_fire,
   input  rca_pkg::req_word_type req_word,
   input  rca_pkg::geom_type     geom,
   input  rca_pkg::cmd_type      cmd,
   input  logic                  rsp_take,
   output rca_pkg::status_type   status,
   output rca_pkg::rsp_word_type rsp_word
);
   import rca_pkg::*;

   // Stage 1: captured pixel.
   logic             p1_valid_ff;
   req_word_type     p1_word_ff;

   // Stage 2: bounds checked, offsets taken.
   logic             p2_valid_ff;
   logic             p2_eof_ff;
   logic [PIX_W-1:0] p2_pixel_ff;
   pixel_format_type p2_fmt_ff;
   logic             p2_nonempty_ff;
   logic             p2_in_x_ff;
   logic             p2_in_y_ff;
   logic [DIM_W-1:0] p2_diff_x_ff;
   logic [DIM_W-1:0] p2_diff_y_ff;

   // Grid multiples per axis.
   logic [OFF_W-1:0] mult_x_ff [GRID_TAPS];
   logic [OFF_W-1:0] mult_y_ff [GRID_TAPS];

   // Accumulators.
   logic [SUM_W-1:0] sum_ff [NUM_CH];
   logic [CNT_W-1:0] cnt_ff;

   // Frame snapshot and divider.
   logic [SUM_W-1:0] work_sum_ff [NUM_CH];
   logic [CNT_W-1:0] work_cnt_ff;
   pixel_format_type fin_fmt_ff;
   logic             fin_nonempty_ff;
   logic [NUM_W-1:0] rem_ff [NUM_CH];
   logic [NUM_W-1:0] den_sh_ff;
   logic [QUO_W-1:0] quo_ff [NUM_CH];

   rsp_word_type     out_word_ff;
   logic             out_full_ff;

   logic [CH_W-1:0]  chan [NUM_CH];
   logic [SUM_W-1:0] sum_in [NUM_CH];
   logic [CNT_W-1:0] cnt_in;
   logic [NUM_W-1:0] den_in;
   logic             on_x;
   logic             on_y;
   logic             hit;
   logic             frame_done;
   logic             result_ok;

   always_ff @(posedge clock) begin
      if (reset) p1_valid_ff <= 1'b0;
      else       p1_valid_ff <= req_fire;
      if (req_fire) p1_word_ff <= req_word;
   end

   always_ff @(posedge clock) begin
      if (reset) p2_valid_ff <= 1'b0;
      else       p2_valid_ff <= p1_valid_ff;
      if (p1_valid_ff) begin
         p2_eof_ff      <= p1_word_ff.end_of_frame;
         p2_pixel_ff    <= p1_word_ff.pixel_word;
         p2_fmt_ff      <= geom.fmt;
         p2_nonempty_ff <= geom.x.ok && geom.y.ok;
         p2_in_x_ff     <= (DIM_W'(p1_word_ff.column) >= geom.x.lo) &&
                           (DIM_W'(p1_word_ff.column) <  geom.x.hi);
         p2_in_y_ff     <= (DIM_W'(p1_word_ff.line) >= geom.y.lo) &&
                           (DIM_W'(p1_word_ff.line) <  geom.y.hi);
         p2_diff_x_ff   <= DIM_W'(p1_word_ff.column) - geom.x.lo;
         p2_diff_y_ff   <= DIM_W'(p1_word_ff.line) - geom.y.lo;
      end
   end

   // Every grid offset inside the span is k * step with k below GRID_TAPS.
   always_ff @(posedge clock) begin
      for (int k = 0; k < GRID_TAPS; k++) begin
         mult_x_ff[k] <= OFF_W'(k) * OFF_W'(geom.x.step);
         mult_y_ff[k] <= OFF_W'(k) * OFF_W'(geom.y.step);
      end
   end

   always_comb begin
      on_x = 1'b0;
      on_y = 1'b0;
      for (int k = 0; k < GRID_TAPS; k++) begin
         if (OFF_W'(p2_diff_x_ff) == mult_x_ff[k]) on_x = 1'b1;
         if (OFF_W'(p2_diff_y_ff) == mult_y_ff[k]) on_y = 1'b1;
      end
      hit        = p2_valid_ff && p2_nonempty_ff && p2_in_x_ff && p2_in_y_ff && on_x && on_y;
      frame_done = p2_valid_ff && p2_eof_ff;
   end

   // Channel unpack.
   always_comb begin
      if (p2_fmt_ff == FMT_RGB10) begin
         chan[CH_RED]   = p2_pixel_ff[CH_W-1:0];
         chan[CH_GREEN] = p2_pixel_ff[2*CH_W-1:CH_W];
         chan[CH_BLUE]  = p2_pixel_ff[3*CH_W-1:2*CH_W];
      end else begin
         chan[CH_RED]   = CH_W'(p2_pixel_ff[3*COLOR_W-1:2*COLOR_W]);
         chan[CH_GREEN] = CH_W'(p2_pixel_ff[2*COLOR_W-1:COLOR_W]);
         chan[CH_BLUE]  = CH_W'(p2_pixel_ff[COLOR_W-1:0]);
      end
      for (int c = 0; c < NUM_CH; c++) begin
         sum_in[c] = hit ? sum_ff[c] + SUM_W'(chan[c]) : sum_ff[c];
      end
      cnt_in = hit ? cnt_ff + CNT_W'(1) : cnt_ff;
   end

   // Accumulate; on the last pixel hand the totals to the divider and restart.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CH; c++) sum_ff[c] <= '0;
         cnt_ff <= '0;
      end else if (frame_done) begin
         for (int c = 0; c < NUM_CH; c++) sum_ff[c] <= '0;
         cnt_ff <= '0;
      end else begin
         for (int c = 0; c < NUM_CH; c++) sum_ff[c] <= sum_in[c];
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_done) begin
         for (int c = 0; c < NUM_CH; c++) work_sum_ff[c] <= sum_in[c];
         work_cnt_ff     <= cnt_in;
         fin_fmt_ff      <= p2_fmt_ff;
         fin_nonempty_ff <= p2_nonempty_ff;
      end
   end

   // Numerator sum*255 and divisor n*1023 in the 10-bit format.
   always_comb begin
      if (fin_fmt_ff == FMT_RGB10) begin
         den_in = (NUM_W'(work_cnt_ff) << CH_W) - NUM_W'(work_cnt_ff);
      end else begin
         den_in = NUM_W'(work_cnt_ff);
      end
   end

   // Restoring division, one quotient bit per lane per step.
   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         for (int c = 0; c < NUM_CH; c++) begin
            if (fin_fmt_ff == FMT_RGB10) begin
               rem_ff[c] <= (NUM_W'(work_sum_ff[c]) << COLOR_W) - NUM_W'(work_sum_ff[c]);
            end else begin
               rem_ff[c] <= NUM_W'(work_sum_ff[c]);
            end
            quo_ff[c] <= '0;
         end
         den_sh_ff <= den_in << (QUO_W - 1);
      end else if (cmd.div_step) begin
         for (int c = 0; c < NUM_CH; c++) begin
            if (rem_ff[c] >= den_sh_ff) begin
               rem_ff[c] <= rem_ff[c] - den_sh_ff;
               quo_ff[c] <= {quo_ff[c][QUO_W-2:0], 1'b1};
            end else begin
               quo_ff[c] <= {quo_ff[c][QUO_W-2:0], 1'b0};
            end
         end
         den_sh_ff <= den_sh_ff >> 1;
      end
   end

   assign result_ok = fin_nonempty_ff && (work_cnt_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_full_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_full_ff <= 1'b1;
      end else if (rsp_take) begin
         out_full_ff <= 1'b0;
      end
      if (cmd.load_out) begin
         out_word_ff.mean_red    <= result_ok ? quo_ff[CH_RED]   : '0;
         out_word_ff.mean_green  <= result_ok ? quo_ff[CH_GREEN] : '0;
         out_word_ff.mean_blue   <= result_ok ? quo_ff[CH_BLUE]  : '0;
         out_word_ff.color_valid <= result_ok;
      end
   end

   assign status.frame_done  = frame_done;
   assign status.eof_in_pipe = (p1_valid_ff && p1_word_ff.end_of_frame) || frame_done;
   assign status.out_full    = out_full_ff;
   assign rsp_word           = out_word_ff;

endmodule

// File: rtl/core/rca_ctrl.sv
// Controller state machine: accumulate, prepare, divide, deliver.
// Depends on rca_pkg; commands rca_datapath.
module rca_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  rca_pkg::status_type status,
   input  logic                rsp_take,
   output rca_pkg::cmd_type    cmd,
   output logic                req_ready
);
   import rca_pkg::*;

   state_type             state_ff;
   state_type             state_in;
   logic [DIV_CNT_W-1:0]  div_cnt_ff;
   logic [DIV_CNT_W-1:0]  div_cnt_in;
   logic                  slot_free;

   assign slot_free = !status.out_full || rsp_take;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_ACCUM:   if (status.frame_done) state_in = ST_PREP;
         ST_PREP:    state_in = ST_DIVIDE;
         ST_DIVIDE:  if (div_cnt_ff == DIV_CNT_W'(QUO_W - 1)) state_in = ST_DELIVER;
         ST_DELIVER: if (slot_free) state_in = ST_ACCUM;
         default:    state_in = ST_ACCUM;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_ready  = 1'b0;
      div_cnt_in = '0;
      unique case (state_ff)
         ST_ACCUM:   req_ready = !status.eof_in_pipe;
         ST_PREP:    cmd.prep = 1'b1;
         ST_DIVIDE:  begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + DIV_CNT_W'(1);
         end
         ST_DELIVER: cmd.load_out = slot_free;
         default:    ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_ACCUM;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

endmodule

// File: rtl/core/region_color_averager_core.sv
// Region color averager, top level: wires the config block, controller and datapath.
// Depends on rca_pkg, rca_ifs, rca_csr, rca_ctrl and rca_datapath.
//
// Usage: pixel words enter on req_ch (pixel, column, line, end_of_frame) at one per
// clock while the frame is streaming. Pixels on the clamped sampling grid of the
// configured rectangle are summed. The word flagged end_of_frame closes the frame:
// its result word (mean red/green/blue, color_valid) leaves on rsp_ch.
// Throughput: one pixel per cycle inside a frame. After an end-of-frame word the
// request side holds ready low while the word passes the 2 pipeline stages, the
// prepare state forms numerator and divisor, the shared-step restoring divider
// runs (one quotient bit per cycle for all three channels) and the result is loaded.
// A held response does not stall pixels: the result register decouples the sides,
// and only the next frame's result waits, with req_ch.ready held low, until the
// previous one is taken.
// csr_* writes one register per cycle (no read-back); write only while idle.
// Reset (synchronous, active high) restores the default geometry and format,
// clears the sums and drops any pending result.
module region_color_averager_core (
   input  logic                           clock,
   input  logic                           reset,
   rca_req_if.sink                        req_ch,
   rca_rsp_if.source                      rsp_ch,
   input  logic                           csr_wr_en,
   input  logic [rca_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rca_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rca_pkg::*;

   geom_type     geom;
   cmd_type      cmd;
   status_type   status;
   rsp_word_type rsp_word;
   logic         req_ready;
   logic         req_fire;
   logic         rsp_take;

   // Handshake completions on both channels.
   assign req_fire = req_ch.valid && req_ready;
   assign rsp_take = rsp_ch.valid && rsp_ch.ready;

   rca_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .geom      (geom)
   );

   rca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .rsp_take  (rsp_take),
      .cmd       (cmd),
      .req_ready (req_ready)
   );

   rca_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .req_word (req_ch.word),
      .geom     (geom),
      .cmd      (cmd),
      .rsp_take (rsp_take),
      .status   (status),
      .rsp_word (rsp_word)
   );

   // Drive the channel ports: ready from the controller, result from its register.
   assign req_ch.ready = req_ready;
   assign rsp_ch.valid = status.out_full;
   assign rsp_ch.word  = rsp_word;

endmodule
